### hdl/llca_pkg.sv
// Shared types and constants of the least-loaded core allocator.
`timescale 1ns / 1ps
package llca_pkg;

	localparam logic [2:0] FN_REGISTER     = 3'd0;
	localparam logic [2:0] FN_UNREGISTER   = 3'd1;
	localparam logic [2:0] FN_DECOMMISSION = 3'd2;
	localparam logic [2:0] FN_RECOMMISSION = 3'd3;
	localparam logic [2:0] FN_ALLOC_LEAST  = 3'd4;
	localparam logic [2:0] FN_ALLOC_CORE   = 3'd5;
	localparam logic [2:0] FN_DEALLOC      = 3'd6;
	localparam logic [2:0] FN_QUERY        = 3'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ABSENT    = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_RANGE     = 3'd3;
	localparam logic [2:0] ST_LIMIT     = 3'd4;
	localparam logic [2:0] ST_DUPLICATE = 3'd5;

	localparam logic [1:0] CFG_MAX_PER_CORE = 2'd0;
	localparam logic [1:0] CFG_CORE0_EXTRA  = 2'd1;

	localparam logic [12:0] MAX_PER_CORE_RST = 13'd1000;
	localparam logic [12:0] CORE0_EXTRA_RST  = 13'd2;

	localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;
	localparam logic [19:0] COUNT_MAX  = 20'hFFFFF;

	typedef struct packed {
		logic [2:0] func;
		logic [3:0] node_id;
		logic [6:0] core_count;
		logic [5:0] core;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] chosen_core;
		logic       node_empty;
		logic [4:0] live_nodes;
	} rsp_t;

	typedef struct packed {
		logic [12:0] max_per_core;
		logic [12:0] core0_extra;
	} cfg_t;

	typedef struct packed {
		logic [19:0] alloc;
		logic [6:0]  cores;
		logic        retired;
	} node_info_t;

endpackage

### hdl/llca_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
module llca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/llca_cfg.sv
// Configuration registers and the registered node capacity product.
`timescale 1ns / 1ps
module llca_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [12:0]       cfg_data,
	input  logic [6:0]        cores,
	output llca_pkg::cfg_t    cfg,
	output logic [19:0]       prod
);
	import llca_pkg::*;

	cfg_t        cfg_q;
	logic [19:0] prod_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_per_core <= MAX_PER_CORE_RST;
			cfg_q.core0_extra  <= CORE0_EXTRA_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MAX_PER_CORE) begin
				cfg_q.max_per_core <= cfg_data;
			end else if (cfg_index == CFG_CORE0_EXTRA) begin
				cfg_q.core0_extra <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 20'(cores) * 20'(cfg_q.max_per_core);
	end

	assign cfg  = cfg_q;
	assign prod = prod_q;

endmodule

### hdl/least_loaded_core_allocator_unit.sv
// Least-loaded core allocator: request sequencer over the node and weight memories.
// Each request reads its node entry in S_NREAD, and its result registers in S_DONE; an in-range
// allocate on a core or a deallocate passes through S_WRD, a least-loaded allocation through S_CAP
// and, unless refused, S_SCAN and S_APPLY, and a register through S_SWEEP; a stalled result waits in S_DONE.
// Throughput: one request at a time; the next one is taken the cycle after the result registers.
// Reset clears the node present flags and the live count and restores the configuration defaults.
`timescale 1ns / 1ps
module least_loaded_core_allocator_unit #(
	parameter int NODES = 16,
	parameter int CORES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  llca_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output llca_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [12:0]    cfg_data
);
	import llca_pkg::*;

	localparam int NW  = $clog2(NODES);
	localparam int CWI = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int CNW = $clog2(CORES + 1);
	localparam int WD  = NODES * CORES;
	localparam int AW  = $clog2(WD);
	localparam int LW  = $clog2(NODES + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_NREAD = 8'b0000_0010,
		S_CAP   = 8'b0000_0100,
		S_SCAN  = 8'b0000_1000,
		S_APPLY = 8'b0001_0000,
		S_WRD   = 8'b0010_0000,
		S_SWEEP = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t           state_q;
	req_t             req_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic [NODES-1:0] present_q;
	logic [LW-1:0]    live_q;
	logic [CNW-1:0]   cnt_q;
	logic             vld_s1;
	logic [CWI-1:0]   core_s1;
	logic [15:0]      best_w_q;
	logic [CWI-1:0]   best_c_q;

	cfg_t        cfg;
	logic [19:0] prod;
	logic [19:0] cap;
	logic        full;

	logic            node_we;
	logic [27:0]     node_wdata;
	logic [27:0]     node_rdata;
	node_info_t      node_rd;
	node_info_t      node_wr;
	logic [NW-1:0]   idx;
	logic            accept;

	logic            wt_we;
	logic [AW-1:0]   wt_waddr;
	logic [15:0]     wt_wdata;
	logic            wt_re;
	logic [AW-1:0]   wt_raddr;
	logic [15:0]     wt_rdata;

	logic [AW-1:0]   node_base;
	logic            id_ok;
	logic            present;
	logic            count_ok;
	logic            core_ok;
	logic            reg_ok;
	logic            ret_set;
	logic            ret_clr;
	logic            issuing;
	logic            apply_ok;
	logic            inc;
	logic            wrd_ok;

	llca_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cores     (node_rd.cores),
		.cfg       (cfg),
		.prod      (prod)
	);

	llca_ram #(.WIDTH(28), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (idx),
		.wdata (node_wdata),
		.re    (accept),
		.raddr (NW'(req.node_id)),
		.rdata (node_rdata)
	);

	llca_ram #(.WIDTH(16), .DEPTH(WD)) u_weight_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (wt_wdata),
		.re    (wt_re),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign node_rd    = node_info_t'(node_rdata);
	assign node_wdata = 28'(node_wr);
	assign idx        = NW'(req_q.node_id);
	assign node_base  = AW'(AW'(idx) * AW'(CORES));

	always_comb begin
		id_ok    = (32'(req_q.node_id) < 32'(NODES));
		present  = id_ok && present_q[idx];
		count_ok = (req_q.core_count != 7'd0) && (32'(req_q.core_count) <= 32'(CORES));
		core_ok  = (7'(req_q.core) < node_rd.cores) && (32'(req_q.core) < 32'(CORES));
		reg_ok   = (state_q == S_NREAD) && (req_q.func == FN_REGISTER) && !present && count_ok;
		ret_set  = (state_q == S_NREAD) && (req_q.func == FN_DECOMMISSION) && present
			&& !node_rd.retired;
		ret_clr  = (state_q == S_NREAD) && (req_q.func == FN_RECOMMISSION) && present
			&& node_rd.retired;
		issuing  = (state_q == S_SCAN) && (32'(cnt_q) < 32'(node_rd.cores));
		apply_ok = (state_q == S_APPLY) && (best_w_q != WEIGHT_MAX)
			&& (node_rd.alloc != COUNT_MAX);
		inc      = (req_q.func == FN_ALLOC_CORE);
		wrd_ok   = (state_q == S_WRD) && (inc
			? ((wt_rdata != WEIGHT_MAX) && (node_rd.alloc != COUNT_MAX))
			: ((wt_rdata != 16'd0) && (node_rd.alloc != 20'd0)));
		cap      = (prod > 20'(cfg.core0_extra)) ? (prod - 20'(cfg.core0_extra)) : 20'd0;
		full     = node_rd.retired || (node_rd.alloc >= cap);
	end

	always_comb begin
		node_we = reg_ok || ret_set || ret_clr || apply_ok || wrd_ok;
		node_wr = node_rd;
		if (reg_ok) begin
			node_wr.alloc   = 20'd0;
			node_wr.cores   = req_q.core_count;
			node_wr.retired = 1'b0;
		end else if (ret_set) begin
			node_wr.retired = 1'b1;
		end else if (ret_clr) begin
			node_wr.retired = 1'b0;
		end else if (apply_ok || (wrd_ok && inc)) begin
			node_wr.alloc = node_rd.alloc + 20'd1;
		end else begin
			node_wr.alloc = node_rd.alloc - 20'd1;
		end
	end

	always_comb begin
		wt_we    = 1'b0;
		wt_waddr = node_base + AW'(req_q.core);
		wt_wdata = inc ? (wt_rdata + 16'd1) : (wt_rdata - 16'd1);
		if (state_q == S_SWEEP) begin
			wt_we    = 1'b1;
			wt_waddr = node_base + AW'(CWI'(cnt_q));
			wt_wdata = (cnt_q == CNW'(0)) ? 16'(cfg.core0_extra) : 16'd0;
		end else if (apply_ok) begin
			wt_we    = 1'b1;
			wt_waddr = node_base + AW'(best_c_q);
			wt_wdata = best_w_q + 16'd1;
		end else if (wrd_ok) begin
			wt_we = 1'b1;
		end
		wt_re    = issuing || (state_q == S_NREAD);
		wt_raddr = issuing ? (node_base + AW'(CWI'(cnt_q))) : (node_base + AW'(req_q.core));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			res_q <= '0;
		end
		if (state_q == S_NREAD) begin
			if (req_q.func == FN_REGISTER) begin
				if (present) begin
					res_q.status <= ST_DUPLICATE;
				end else if (!count_ok) begin
					res_q.status <= ST_RANGE;
				end
			end else if (!present) begin
				res_q.status <= ST_ABSENT;
			end else if ((req_q.func == FN_ALLOC_CORE) || (req_q.func == FN_DEALLOC)) begin
				if (!core_ok) begin
					res_q.status <= ST_RANGE;
				end
			end else if (req_q.func == FN_QUERY) begin
				res_q.node_empty <= (node_rd.alloc == 20'd0);
			end
		end
		if ((state_q == S_CAP) && full) begin
			res_q.status <= ST_FULL;
		end
		if (state_q == S_APPLY) begin
			if (apply_ok) begin
				res_q.chosen_core <= 6'(best_c_q);
			end else begin
				res_q.status <= ST_LIMIT;
			end
		end
		if ((state_q == S_WRD) && !wrd_ok) begin
			res_q.status <= ST_LIMIT;
		end
		if ((state_q == S_SCAN) && vld_s1) begin
			if ((core_s1 == CWI'(0)) || (wt_rdata < best_w_q)) begin
				best_w_q <= wt_rdata;
				best_c_q <= core_s1;
			end
		end
		core_s1 <= CWI'(cnt_q);
		if ((state_q == S_DONE) && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= rsp_t'({res_q.status, res_q.chosen_core, res_q.node_empty, 5'(live_q)});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			present_q   <= '0;
			live_q      <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= issuing;
			if (issuing) begin
				cnt_q <= cnt_q + CNW'(1);
			end
			if ((state_q == S_DONE) && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (reg_ok) begin
				present_q[idx] <= 1'b1;
				live_q         <= live_q + LW'(1);
			end else if (ret_clr) begin
				live_q <= live_q + LW'(1);
			end else if (ret_set) begin
				live_q <= live_q - LW'(1);
			end else if ((state_q == S_NREAD) && (req_q.func == FN_UNREGISTER) && present) begin
				present_q[idx] <= 1'b0;
				if (!node_rd.retired) begin
					live_q <= live_q - LW'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_NREAD;
					end
				end
				S_NREAD: begin
					cnt_q <= '0;
					if (reg_ok) begin
						state_q <= S_SWEEP;
					end else if ((req_q.func == FN_ALLOC_LEAST) && present) begin
						state_q <= S_CAP;
					end else if (((req_q.func == FN_ALLOC_CORE)
						|| (req_q.func == FN_DEALLOC)) && present && core_ok) begin
						state_q <= S_WRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_CAP: begin
					cnt_q   <= '0;
					state_q <= full ? S_DONE : S_SCAN;
				end
				S_SCAN: begin
					if (!issuing && !vld_s1) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_DONE;
				end
				S_WRD: begin
					state_q <= S_DONE;
				end
				S_SWEEP: begin
					if (cnt_q == CNW'(CORES - 1)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CNW'(1);
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
